@@ sv/lkvc_pkg.sv @@
// Shared types and constants for the LRU key-value cache.
// No dependencies; imported by every module of the block.
`default_nettype none

package lkvc_pkg;

    localparam int DATA_W = 32;
    localparam int CAP_W  = 5;

    localparam logic [CAP_W-1:0]  CAP_RESET  = 5'd16;
    localparam logic [DATA_W-1:0] MISS_VALUE = 32'hFFFF_FFFF;
    localparam logic [DATA_W-1:0] PUT_VALUE  = 32'h0000_0000;

    localparam logic REQ_GET = 1'b0;
    localparam logic REQ_PUT = 1'b1;

    typedef struct packed {
        logic                     req_type;
        logic signed [DATA_W-1:0] key;
        logic signed [DATA_W-1:0] value;
    } lkvc_req_t;

    typedef struct packed {
        logic                     hit;
        logic signed [DATA_W-1:0] read_value;
    } lkvc_rsp_t;

endpackage

`default_nettype wire

@@ sv/lkvc_req_stage.sv @@
// Input register for cache requests.
// Depends on lkvc_pkg; feeds lkvc_engine.
`default_nettype none

module lkvc_req_stage (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire lkvc_pkg::lkvc_req_t in_req,
    output logic                    req_valid,
    output lkvc_pkg::lkvc_req_t     req,
    input  wire logic               take
);
    import lkvc_pkg::*;

    logic      valid_reg;
    lkvc_req_t req_reg;

    assign in_ready  = !valid_reg || take;
    assign req_valid = valid_reg;
    assign req       = req_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            req_reg <= in_req;
        end
    end

endmodule

`default_nettype wire

@@ sv/lkvc_engine.sv @@
// Entry store, parallel key match, LRU rank update and result register.
// Depends on lkvc_pkg; driven by lkvc_req_stage.
`default_nettype none

module lkvc_engine #(
    parameter int ENTRIES = 16
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic [lkvc_pkg::CAP_W-1:0]  cap,
    input  wire logic                        req_valid,
    input  wire lkvc_pkg::lkvc_req_t         req,
    output logic                             take,
    output logic                             out_valid,
    input  wire logic                        out_ready,
    output lkvc_pkg::lkvc_rsp_t              out_rsp
);
    import lkvc_pkg::*;

    localparam int RW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CW = $clog2(ENTRIES + 1);
    localparam int XW = (CW > CAP_W) ? CW : CAP_W;

    logic              valid_reg [ENTRIES];
    logic [DATA_W-1:0] key_reg   [ENTRIES];
    logic [DATA_W-1:0] val_reg   [ENTRIES];
    logic [RW-1:0]     rank_reg  [ENTRIES];
    logic [CW-1:0]     count_reg;
    logic              out_valid_reg;
    lkvc_rsp_t         rsp_reg;
    lkvc_rsp_t         rsp_next;

    logic [ENTRIES-1:0] match;
    logic [ENTRIES-1:0] lru;
    logic [ENTRIES-1:0] free;
    logic [ENTRIES-1:0] tgt;
    logic [DATA_W-1:0]  rd;
    logic [CW-1:0]      r_sel;
    logic [CW-1:0]      r_lim;
    logic [XW-1:0]      cap_x;
    logic [XW-1:0]      eff_x;
    logic               hit;
    logic               is_put;
    logic               insert;
    logic               fire;
    logic               upd;

    assign take      = !out_valid_reg || out_ready;
    assign fire      = req_valid && take;
    assign out_valid = out_valid_reg;
    assign out_rsp   = rsp_reg;
    assign is_put    = (req.req_type == REQ_PUT);

    // capacity clamped to 1..ENTRIES
    always_comb
    begin
        cap_x = XW'(cap);
        if (cap == '0)
            eff_x = XW'(1);
        else if (cap_x > XW'(ENTRIES))
            eff_x = XW'(ENTRIES);
        else
            eff_x = cap_x;
    end

    always_comb
    begin
        rd    = '0;
        r_sel = '0;
        for (int i = 0; i < ENTRIES; i++)
        begin
            match[i] = valid_reg[i] && (key_reg[i] == req.key);
            lru[i]   = valid_reg[i] && (CW'(rank_reg[i]) == (count_reg - CW'(1)));
            // valid entries always fill the lowest slots, so the free slot is the count
            free[i]  = (CW'(i) == count_reg);
        end
        hit    = |match;
        insert = is_put && !hit && (XW'(count_reg) < eff_x);
        priority if (hit)
            tgt = match;
        else if (insert)
            tgt = free;
        else
            tgt = lru;
        for (int i = 0; i < ENTRIES; i++)
        begin
            if (match[i])
                rd = rd | val_reg[i];
            if (tgt[i])
                r_sel = r_sel | CW'(rank_reg[i]);
        end
        r_lim = insert ? count_reg : r_sel;
        upd   = fire && (hit || is_put);

        rsp_next.hit = hit;
        priority if (is_put)
            rsp_next.read_value = PUT_VALUE;
        else if (hit)
            rsp_next.read_value = rd;
        else
            rsp_next.read_value = MISS_VALUE;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < ENTRIES; i++)
            begin
                valid_reg[i] <= 1'b0;
                rank_reg[i]  <= '0;
            end
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (take)
                out_valid_reg <= req_valid;
            if (upd)
            begin
                for (int i = 0; i < ENTRIES; i++)
                begin
                    if (tgt[i])
                        rank_reg[i] <= '0;
                    else if (valid_reg[i] && (CW'(rank_reg[i]) < r_lim))
                        rank_reg[i] <= rank_reg[i] + RW'(1);
                    if (insert && tgt[i])
                        valid_reg[i] <= 1'b1;
                end
                if (insert)
                    count_reg <= count_reg + CW'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
            rsp_reg <= rsp_next;
        if (upd && is_put)
        begin
            for (int i = 0; i < ENTRIES; i++)
            begin
                if (tgt[i])
                begin
                    val_reg[i] <= req.value;
                    if (!hit)
                        key_reg[i] <= req.key;
                end
            end
        end
    end

endmodule

`default_nettype wire

@@ sv/lru_key_value_cache_core.sv @@
// Fully associative key-value cache with LRU replacement, top level.
// Depends on lkvc_pkg, lkvc_req_stage and lkvc_engine.
//
// Usage:
//   Requests enter on in_valid/in_ready with in_req (get or put, key, value).
//   Each request gives exactly one response on out_valid/out_ready with
//   out_rsp: hit flag and read value (stored value on a get hit, all ones
//   on a get miss, zero for a put).
//   A taken request passes the input register, then the result register.
//   Throughput is one request per cycle while the receiver takes responses:
//   the lookup, rank update and replacement are a single pass of parallel
//   compare logic over all ENTRIES slots, between the input register and
//   the result register. When the receiver stalls, the response is held and
//   one further request is buffered in the input register; in_ready then drops.
//   Reset clears all valid marks, ranks and the entry count, and sets the
//   capacity register to 16. cfg_wr_en writes capacity; the user must assert
//   it only while idle, the block does not enforce this. A value of zero acts
//   as one and values above ENTRIES act as ENTRIES.
`default_nettype none

module lru_key_value_cache_core #(
    parameter int ENTRIES = 16
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       in_valid,
    output logic                            in_ready,
    input  wire lkvc_pkg::lkvc_req_t        in_req,
    output logic                            out_valid,
    input  wire logic                       out_ready,
    output lkvc_pkg::lkvc_rsp_t             out_rsp,
    input  wire logic                       cfg_wr_en,
    input  wire logic [lkvc_pkg::CAP_W-1:0] cfg_wr_data
);
    import lkvc_pkg::*;

    logic [CAP_W-1:0] cap_reg;
    logic             req_valid;
    lkvc_req_t        req;
    logic             take;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cap_reg <= CAP_RESET;
        else if (cfg_wr_en)
            cap_reg <= cfg_wr_data;
    end

    lkvc_req_stage u_req_stage (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_req    (in_req),
        .req_valid (req_valid),
        .req       (req),
        .take      (take)
    );

    lkvc_engine #(
        .ENTRIES (ENTRIES)
    ) u_engine (
        .clk       (clk),
        .rst_n     (rst_n),
        .cap       (cap_reg),
        .req_valid (req_valid),
        .req       (req),
        .take      (take),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_rsp   (out_rsp)
    );

endmodule

`default_nettype wire

@@ sv/lkvc_checker.sv @@
// Port-level checks for lru_key_value_cache_core, bound to the top level.
// Depends on lkvc_pkg.
`default_nettype none

module lkvc_checker (
    input wire logic                clk,
    input wire logic                rst_n,
    input wire logic                in_valid,
    input wire logic                in_ready,
    input wire logic                out_valid,
    input wire logic                out_ready,
    input wire lkvc_pkg::lkvc_rsp_t out_rsp
);
    import lkvc_pkg::*;

    // stalled response holds
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_rsp))
        else $error("response changed while stalled");

    // a miss carries either the put code or the get-miss code
    a_miss_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_rsp.hit |->
            out_rsp.read_value == PUT_VALUE || out_rsp.read_value == MISS_VALUE)
        else $error("bad read value on miss");

    // a response rises only after a request was taken, through the input and result registers
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_valid && in_ready, 2))
        else $error("response without request");

    // response only withdrawn once taken
    a_no_drop: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(out_valid) |-> $past(out_ready))
        else $error("response dropped");

endmodule

bind lru_key_value_cache_core lkvc_checker u_lkvc_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_rsp   (out_rsp)
);

`default_nettype wire
